// ----- hdl/line_buffered_tx_framer_macros.svh -----
// Assertion macros for the framer.
`ifndef LINE_BUFFERED_TX_FRAMER_MACROS_SVH
`define LINE_BUFFERED_TX_FRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LBTF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LBTF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/lbtf_pkg.sv -----
package lbtf_pkg;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam int SLACK = 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // One classified character on its way from front to back.
  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
    logic       force_lf;
  } cmd_t;

  typedef struct packed {
    logic draining;
    logic popping;
  } bk_status_t;

  typedef enum logic [3:0] {
    ST_FILL      = 4'b0001,
    ST_DRAIN_MEM = 4'b0010,
    ST_DRAIN_LF  = 4'b0100,
    ST_DRAIN_CR  = 4'b1000
  } bk_state_t;

  typedef enum logic [1:0] {
    K_MEM = 2'd0,
    K_LF  = 2'd1,
    K_CR  = 2'd2
  } out_kind_t;

endpackage

// ----- hdl/lbtf_front.sv -----
module lbtf_front #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    char_in,
  input  logic          q_full,
  output logic          push,
  output lbtf_pkg::cmd_t push_data
);
  import lbtf_pkg::*;

  localparam int CNT_W = $clog2(LINE_CAPACITY);

  logic [CNT_W-1:0] count;
  logic             at_limit;
  logic             is_lf;

  assign at_limit = (count == CNT_W'(LINE_CAPACITY - SLACK - 1));
  assign is_lf    = (char_in == CH_LF);

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  assign push_data.ch       = char_in;
  assign push_data.eol      = at_limit || is_lf;
  assign push_data.force_lf = at_limit && !is_lf;

  // Track the line length; restart on every end of line.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      if (push_data.eol) begin
        count <= '0;
      end else begin
        count <= count + 1'b1;
      end
    end
  end

endmodule

// ----- hdl/lbtf_queue.sv -----
module lbtf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lbtf_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output lbtf_pkg::cmd_t pop_data,
  output logic           empty
);
  import lbtf_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] used;

  assign full     = (used == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (used == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   used <= used + 1'b1;
        2'b01:   used <= used - 1'b1;
        default: used <= used;
      endcase
    end
  end

endmodule

// ----- hdl/lbtf_back.sv -----
module lbtf_back #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  input  lbtf_pkg::cmd_t       cmd,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           char_out,
  output logic                 last_of_line,
  output lbtf_pkg::bk_status_t status
);
  import lbtf_pkg::*;

  localparam int IDX_W = $clog2(LINE_CAPACITY);

  logic [7:0]       mem [LINE_CAPACITY];
  logic [7:0]       rd_data;
  bk_state_t        state;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] last_idx;
  logic             force_lf;
  logic             out_valid_q;
  out_kind_t        out_kind;
  logic             adv;

  assign adv = !out_valid_q || !out_stall;
  assign pop = (state == ST_FILL) && cmd_valid;

  assign status.draining = (state != ST_FILL);
  assign status.popping  = pop;

  assign out_valid    = out_valid_q;
  assign last_of_line = (out_kind == K_CR);

  always_comb begin
    unique case (out_kind)
      K_MEM:   char_out = rd_data;
      K_LF:    char_out = CH_LF;
      K_CR:    char_out = CH_CR;
      default: char_out = rd_data;
    endcase
  end

  // Line store: one write while filling, one registered read while draining.
  always_ff @(posedge clk) begin
    if (pop) begin
      mem[wr_idx] <= cmd.ch;
    end
    if ((state == ST_DRAIN_MEM) && adv) begin
      rd_data <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_FILL;
      wr_idx      <= '0;
      rd_idx      <= '0;
      last_idx    <= '0;
      force_lf    <= 1'b0;
      out_valid_q <= 1'b0;
      out_kind    <= K_MEM;
    end else begin
      // Every drain state loads one byte per advance; filling loads nothing.
      if (adv) begin
        out_valid_q <= (state != ST_FILL);
      end
      unique case (state)
        ST_FILL: begin
          if (cmd_valid) begin
            if (cmd.eol) begin
              state    <= ST_DRAIN_MEM;
              last_idx <= wr_idx;
              force_lf <= cmd.force_lf;
              rd_idx   <= '0;
            end else begin
              wr_idx <= wr_idx + 1'b1;
            end
          end
        end
        ST_DRAIN_MEM: begin
          if (adv) begin
            out_kind <= K_MEM;
            rd_idx   <= rd_idx + 1'b1;
            if (rd_idx == last_idx) begin
              state <= force_lf ? ST_DRAIN_LF : ST_DRAIN_CR;
            end
          end
        end
        ST_DRAIN_LF: begin
          if (adv) begin
            out_kind <= K_LF;
            state    <= ST_DRAIN_CR;
          end
        end
        ST_DRAIN_CR: begin
          if (adv) begin
            out_kind <= K_CR;
            state    <= ST_FILL;
            wr_idx   <= '0;
          end
        end
        default: state <= ST_FILL;
      endcase
    end
  end

endmodule

// ----- hdl/line_buffered_tx_framer.sv -----
// Line-buffered transmit framer. Characters enter one per cycle, while in_stall
// is low, on the input channel and collect in a line store of LINE_CAPACITY
// bytes. A line ends on a line feed, or after LINE_CAPACITY - 2 characters,
// where a line feed is forced in; a carriage return always follows, and the
// whole line goes out in order with last_of_line set on that carriage return.
// The input takes one request per cycle while a line fills, since the store
// takes one write per cycle. A finished line (characters, line feed, carriage
// return) drains one byte per cycle while out_stall is low, through the
// store's single read port; during the drain the input still takes up to two
// requests into the queue between front and back, then stalls until the back
// has returned to filling and popped a request from the queue.
`include "line_buffered_tx_framer_macros.svh"

module line_buffered_tx_framer #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] char_out,
  output logic       last_of_line
);
  import lbtf_pkg::*;

  // Classified requests between front and back.
  logic       q_push;
  cmd_t       q_push_data;
  logic       q_full;
  logic       q_pop;
  cmd_t       q_pop_data;
  logic       q_empty;
  bk_status_t bk_status;

  // Front: accept characters, count the line, mark its end and forced LF.
  lbtf_front #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .char_in  (char_in),
    .q_full   (q_full),
    .push     (q_push),
    .push_data(q_push_data)
  );

  // Short queue: hold requests while the back drains a line.
  lbtf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_push_data),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_pop_data),
    .empty    (q_empty)
  );

  // Back: store characters, then drain the line plus any forced LF and the CR.
  lbtf_back #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (!q_empty),
    .cmd         (q_pop_data),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .char_out    (char_out),
    .last_of_line(last_of_line),
    .status      (bk_status)
  );

  // The byte marked last is always the carriage return.
  `LBTF_ASSERT_NOW(a_last_is_cr, clk, rst, out_valid && last_of_line, char_out == CH_CR, "last byte is not CR")
  // Bytes before the carriage return only appear while a line drains.
  `LBTF_ASSERT_NOW(a_body_in_drain, clk, rst, out_valid && !last_of_line, bk_status.draining, "line byte outside drain")
  // Never take from the queue while draining.
  `LBTF_ASSERT_NOW(a_no_pop_in_drain, clk, rst, bk_status.draining, !bk_status.popping, "queue popped during drain")

endmodule

// ----- test/tb_line_buffered_tx_framer.sv -----
module tb_line_buffered_tx_framer;
  timeunit 1ns;
  timeprecision 1ps;

  import lbtf_pkg::CH_LF;
  import lbtf_pkg::CH_CR;
  import lbtf_pkg::SLACK;

  localparam int LINE_CAP    = 64;
  localparam int LINE_LIMIT  = LINE_CAP - SLACK;  // characters before a forced line feed
  localparam int RANDOM_CHARS = 140;
  localparam int TAIL_CYCLES = 20;
  localparam int CYCLE_LIMIT = 500000;

  // One byte of a flushed line as it should appear on the output channel.
  typedef struct {
    logic [7:0] ch;
    logic       last;
  } line_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] char_in = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] char_out;
  logic       last_of_line;

  // Characters of the line being collected, and bytes of flushed lines not yet seen.
  logic [7:0] open_line[$];
  line_byte_t line_bytes[$];

  int mismatches  = 0;
  int cycle_count = 0;
  int chars_sent  = 0;

  line_buffered_tx_framer #(
    .LINE_CAPACITY(LINE_CAP)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .char_in     (char_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .char_out    (char_out),
    .last_of_line(last_of_line)
  );

  always #6 clk = ~clk;

  // Print one line per mismatch and count it; the run carries on.
  task automatic flag_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("mismatch on %s at cycle %0d: got %h, want %h", what, cycle_count, got, want);
    mismatches++;
  endtask

  // Frame one accepted character: append it, force a line feed at the limit,
  // and on a trailing line feed close the line with a carriage return and
  // queue every byte of it for the output check.
  task automatic frame_char(input logic [7:0] c);
    line_byte_t b;
    if (open_line.size() < LINE_LIMIT) begin
      open_line.push_back(c);
    end
    if (open_line.size() == LINE_LIMIT && c != CH_LF) begin
      open_line.push_back(CH_LF);
    end
    if (open_line.size() > 0 && open_line[$] == CH_LF) begin
      open_line.push_back(CH_CR);
      foreach (open_line[k]) begin
        b.ch   = open_line[k];
        b.last = (k == open_line.size() - 1);
        line_bytes.push_back(b);
      end
      open_line.delete();
    end
  endtask

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Send one request and hold it until the block takes it. Keep valid high
  // when no gap follows so that back-to-back requests see no bubble.
  task automatic send_char(input logic [7:0] c, input bit allow_gap);
    int gap;
    in_valid <= 1'b1;
    char_in  <= c;
    do @(posedge clk); while (in_stall);
    frame_char(c);
    chars_sent++;
    gap = allow_gap ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and hold off until every flushed byte has come out.
  task automatic wait_line_drained();
    if (line_bytes.size() != 0) begin
      in_valid <= 1'b0;
      while (line_bytes.size() != 0) @(posedge clk);
    end
  endtask

  // Random character that is never a line feed.
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == CH_LF) c = 8'h8A;
    return c;
  endfunction

  // Short lines: empty line, field extremes, a carriage return inside a line,
  // and a line that opens with a carriage return.
  task automatic test_short_lines();
    send_char(CH_LF, 1'b1);
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    send_char(CH_CR, 1'b1);
    send_char(8'h55, 1'b0);
    send_char(8'hAA, 1'b0);
    send_char(CH_LF, 1'b0);
    send_char(CH_LF, 1'b0);
    send_char(CH_CR, 1'b1);
    send_char(CH_LF, 1'b1);
  endtask

  // A line that reaches the limit without a line feed: one must be forced in
  // and the full-capacity line flushed in the same step.
  task automatic test_forced_line_feed();
    for (int k = 0; k < LINE_LIMIT; k++) begin
      send_char(plain_char(), 1'b1);
    end
    // the store must start empty again
    send_char(8'h41, 1'b0);
    send_char(CH_LF, 1'b0);
  endtask

  // The character that reaches the limit is itself a line feed: no forced
  // line feed, just the carriage return.
  task automatic test_line_feed_at_limit();
    for (int k = 0; k < LINE_LIMIT - 1; k++) begin
      send_char(plain_char(), 1'b0);
    end
    send_char(CH_LF, 1'b0);
  endtask

  // Let a long line drain completely before sending more.
  task automatic test_drain_pause();
    for (int k = 0; k < 40; k++) begin
      send_char(plain_char(), 1'b0);
    end
    send_char(CH_LF, 1'b0);
    wait_line_drained();
    send_char(CH_LF, 1'b1);
  endtask

  // Random lines: mostly well-formed lines of random content, a few near or
  // at the limit, and some noise with line feeds anywhere.
  task automatic test_random_lines();
    int kind;
    int len;
    int start;
    bit gaps;
    start = chars_sent;
    while (chars_sent - start < RANDOM_CHARS) begin
      kind = $urandom_range(0, 99);
      gaps = ($urandom_range(0, 3) != 0);
      if (kind < 70) begin
        len = $urandom_range(0, 12);
        for (int k = 0; k < len; k++) send_char(plain_char(), gaps);
        send_char(CH_LF, gaps);
      end else if (kind < 80) begin
        len = $urandom_range(LINE_LIMIT - 6, LINE_LIMIT);
        for (int k = 0; k < len; k++) send_char(plain_char(), gaps);
        if (len < LINE_LIMIT) send_char(CH_LF, gaps);
      end else begin
        len = $urandom_range(1, 10);
        for (int k = 0; k < len; k++) begin
          send_char(($urandom_range(0, 3) == 0) ? CH_LF : 8'($urandom_range(0, 255)), gaps);
        end
      end
      if ($urandom_range(0, 19) == 0) wait_line_drained();
    end
    // close whatever is still open
    send_char(CH_LF, 1'b1);
  endtask

  // Output side: check each accepted byte against the oldest expected one,
  // then pick the next stall value. Stalls come in quiet stretches, short
  // bursts and a few long holds.
  int stall_left = 0;
  int quiet_left = 0;

  always @(posedge clk) begin
    line_byte_t want;
    if (!rst && out_valid && !out_stall) begin
      if (line_bytes.size() == 0) begin
        flag_mismatch("unexpected byte", char_out, 8'h00);
      end else begin
        want = line_bytes.pop_front();
        if (char_out !== want.ch) flag_mismatch("char_out", char_out, want.ch);
        if (last_of_line !== want.last) begin
          flag_mismatch("last_of_line", {7'd0, last_of_line}, {7'd0, want.last});
        end
      end
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (quiet_left > 0) begin
      out_stall <= 1'b0;
      quiet_left--;
    end else begin
      out_stall <= 1'b0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: quiet_left = $urandom_range(3, 40);
        9:             stall_left = $urandom_range(10, 30);
        default:       stall_left = $urandom_range(1, 3);
      endcase
    end
  end

  // Cycle budget: end the run if it hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_short_lines();
    test_forced_line_feed();
    test_line_feed_at_limit();
    test_drain_pause();
    test_random_lines();
    in_valid <= 1'b0;
    while (line_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- line_buffered_tx_framer.f -----
+incdir+hdl
hdl/lbtf_pkg.sv
hdl/lbtf_front.sv
hdl/lbtf_queue.sv
hdl/lbtf_back.sv
hdl/line_buffered_tx_framer.sv
test/tb_line_buffered_tx_framer.sv
